// ===== sv/qtbf_pkg.sv =====
// Shared types, codes and constants of the quoted token boundary finder.
package qtbf_pkg;

  localparam int DEF_MAX_LINE       = 4096;
  localparam int DEF_NUM_SEPARATORS = 4;
  localparam int SEP_REGS           = 4;
  localparam int POS_CAP            = 4096;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam logic [2:0] CFG_SEP_COUNT = 3'd0;
  localparam logic [2:0] CFG_SEP_A     = 3'd1;
  localparam logic [2:0] CFG_SEP_B     = 3'd2;
  localparam logic [2:0] CFG_SEP_C     = 3'd3;
  localparam logic [2:0] CFG_SEP_D     = 3'd4;

  localparam logic KIND_TOKEN   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_QUOTE    = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [11:0] TOKENS_MAX = 12'hFFF;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] token_begin;
    logic [11:0] token_end;
    logic [10:0] token_number;
    logic [11:0] token_total;
    logic [1:0]  line_status;
    logic        last;
  } qtbf_result_t;

endpackage

// ===== sv/quoted_token_boundary_finder_unit.sv =====
// Top level of the quoted token boundary finder: line state, result queue, registers.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   char_code, has_char, end_of_line
//   out      output     out_valid / out_ready result_kind .. last
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input word is taken per cycle while the queue has room; its line state update is done in the same cycle.
// A word yields up to two result words, which wait in a four-entry result queue;
// a word that ends a token and its line therefore takes two queue entries.
// Input is taken while the queue has room for two entries; rst clears state and queue.
// Configuration writes are always taken, but have no effect while rst is high.
module quoted_token_boundary_finder_unit #(
  parameter int MAX_LINE       = qtbf_pkg::DEF_MAX_LINE,
  parameter int NUM_SEPARATORS = qtbf_pkg::DEF_NUM_SEPARATORS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        has_char,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [11:0] token_begin,
  output logic [11:0] token_end,
  output logic [10:0] token_number,
  output logic [11:0] token_total,
  output logic [1:0]  line_status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import qtbf_pkg::*;

  localparam int LINE_LIMIT = (MAX_LINE < POS_CAP) ? MAX_LINE : POS_CAP;
  localparam int SEP_LIMIT  = (NUM_SEPARATORS < SEP_REGS) ? NUM_SEPARATORS : SEP_REGS;
  localparam int DEPTH      = 4;

  logic [2:0]  separator_count;
  logic [7:0]  sep_reg [SEP_REGS];

  logic        inside_quote;
  logic        inside_token;
  logic [12:0] char_position;
  logic [11:0] start_position;
  logic [11:0] tokens_so_far;
  logic        overflowed;

  qtbf_result_t fifo [DEPTH];
  logic [1:0]  rd_ptr;
  logic [1:0]  wr_ptr;
  logic [2:0]  count;

  logic        accept;
  logic        pop;
  logic [2:0]  sep_used;
  logic        is_sep;
  logic        quote_1;
  logic        token_1;
  logic [12:0] pos_1;
  logic [11:0] start_1;
  logic        ovf_1;
  logic        emit_a;
  logic        emit_b;
  logic        emit_tok;
  logic [11:0] tok_begin;
  logic [11:0] tok_end;
  logic [11:0] tokens_2;
  logic [1:0]  status;
  qtbf_result_t tok_res;
  qtbf_result_t sum_res;
  qtbf_result_t slot0;
  qtbf_result_t slot1;
  logic [1:0]  push_n;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count <= 3'(DEPTH - 2));
  assign accept    = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;

  always_comb begin
    sep_used = (separator_count > 3'(SEP_LIMIT)) ? 3'(SEP_LIMIT) : separator_count;
    is_sep   = 1'b0;
    for (int k = 0; k < SEP_REGS; k++) begin
      if ((3'(k) < sep_used) && (sep_reg[k] == char_code)) begin
        is_sep = 1'b1;
      end
    end
  end

  always_comb begin
    quote_1   = inside_quote;
    token_1   = inside_token;
    pos_1     = char_position;
    start_1   = start_position;
    ovf_1     = overflowed;
    emit_a    = 1'b0;
    tok_begin = start_position;
    tok_end   = char_position[11:0] - 12'd1;
    if (has_char) begin
      if (char_position >= 13'(LINE_LIMIT)) begin
        ovf_1 = 1'b1;
      end else begin
        pos_1 = char_position + 13'd1;
        if (inside_quote) begin
          if (char_code == CHAR_QUOTE) begin
            quote_1 = 1'b0;
          end
        end else if (char_code == CHAR_QUOTE) begin
          quote_1 = 1'b1;
          start_1 = char_position[11:0];
          token_1 = 1'b1;
        end else if (char_code == CHAR_SPACE || char_code == CHAR_TAB ||
                     char_code == CHAR_LF || is_sep) begin
          if (inside_token) begin
            emit_a  = 1'b1;
            token_1 = 1'b0;
          end
        end else if (!inside_token) begin
          start_1 = char_position[11:0];
          token_1 = 1'b1;
        end
      end
    end
    emit_b = end_of_line && !quote_1 && token_1 && (pos_1 != 13'd0);
    if (!emit_a) begin
      tok_begin = start_1;
      tok_end   = 12'(pos_1 - 13'd1);
    end
    emit_tok = emit_a || emit_b;
    tokens_2 = (emit_tok && tokens_so_far < TOKENS_MAX) ? tokens_so_far + 12'd1
                                                         : tokens_so_far;
    if (ovf_1) begin
      status = STATUS_TOO_LONG;
    end else if (quote_1) begin
      status = STATUS_QUOTE;
    end else begin
      status = STATUS_OK;
    end

    tok_res = '{result_kind: KIND_TOKEN, token_begin: tok_begin, token_end: tok_end,
                token_number: tokens_so_far[10:0], token_total: 12'd0,
                line_status: STATUS_OK, last: 1'b0};
    sum_res = '{result_kind: KIND_SUMMARY, token_begin: 12'd0, token_end: 12'd0,
                token_number: 11'd0, token_total: tokens_2,
                line_status: status, last: 1'b1};
    if (emit_tok) begin
      slot0  = tok_res;
      slot1  = sum_res;
      push_n = end_of_line ? 2'd2 : 2'd1;
    end else begin
      slot0  = sum_res;
      slot1  = sum_res;
      push_n = end_of_line ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_count <= 3'd0;
      sep_reg[0]      <= 8'd44;
      sep_reg[1]      <= 8'd0;
      sep_reg[2]      <= 8'd0;
      sep_reg[3]      <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEP_COUNT: separator_count <= cfg_data[2:0];
        CFG_SEP_A:     sep_reg[0] <= cfg_data;
        CFG_SEP_B:     sep_reg[1] <= cfg_data;
        CFG_SEP_C:     sep_reg[2] <= cfg_data;
        CFG_SEP_D:     sep_reg[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quote   <= 1'b0;
      inside_token   <= 1'b0;
      char_position  <= 13'd0;
      start_position <= 12'd0;
      tokens_so_far  <= 12'd0;
      overflowed     <= 1'b0;
    end else if (accept) begin
      if (end_of_line) begin
        inside_quote   <= 1'b0;
        inside_token   <= 1'b0;
        char_position  <= 13'd0;
        start_position <= 12'd0;
        tokens_so_far  <= 12'd0;
        overflowed     <= 1'b0;
      end else begin
        inside_quote   <= quote_1;
        inside_token   <= token_1;
        char_position  <= pos_1;
        start_position <= start_1;
        tokens_so_far  <= tokens_2;
        overflowed     <= ovf_1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      fifo[wr_ptr] <= slot0;
    end
    if (accept && push_n == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? 3'(push_n) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign result_kind  = fifo[rd_ptr].result_kind;
  assign token_begin  = fifo[rd_ptr].token_begin;
  assign token_end    = fifo[rd_ptr].token_end;
  assign token_number = fifo[rd_ptr].token_number;
  assign token_total  = fifo[rd_ptr].token_total;
  assign line_status  = fifo[rd_ptr].line_status;
  assign last         = fifo[rd_ptr].last;

endmodule

// ===== sv/qtbf_checker.sv =====
// Port-level checks of the quoted token boundary finder and their bind.
module qtbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [11:0] token_begin,
  input logic [11:0] token_end,
  input logic [10:0] token_number,
  input logic [11:0] token_total,
  input logic [1:0]  line_status,
  input logic        last
);
  import qtbf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(last))
    else $error("stalled result word changed");

  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_SUMMARY |->
      last && token_begin == 12'd0 && token_end == 12'd0 && token_number == 11'd0 &&
      line_status != 2'd3)
    else $error("malformed summary word");

  a_token_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_TOKEN |->
      !last && token_total == 12'd0 && line_status == STATUS_OK)
    else $error("malformed token word");

  a_in_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_ready && !out_valid)
    else $error("block not empty after reset");

endmodule

bind quoted_token_boundary_finder_unit qtbf_checker u_qtbf_checker (.*);
